FILE: design/tfd_pkg.sv
package tfd_pkg;

    localparam int ELEV_BITS  = 16;
    localparam int DROP_BITS  = ELEV_BITS + 1;
    // a cardinal drop is shifted by 16; a diagonal drop times 46341 fits in the same width
    localparam int SCORE_BITS = ELEV_BITS + 17;
    localparam int LANES      = 8;
    localparam int LANE_IDX_BITS = $clog2(LANES);
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int POS_BITS       = 16;

    localparam logic [15:0] Q16_INV_SQRT2 = 16'd46341;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SINGLE_FLOW  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 2'd2;

    localparam logic [7:0] DIR_E  = 8'd1;
    localparam logic [7:0] DIR_SE = 8'd2;
    localparam logic [7:0] DIR_S  = 8'd4;
    localparam logic [7:0] DIR_SW = 8'd8;
    localparam logic [7:0] DIR_W  = 8'd16;
    localparam logic [7:0] DIR_NW = 8'd32;
    localparam logic [7:0] DIR_N  = 8'd64;
    localparam logic [7:0] DIR_NE = 8'd128;

    // lanes run over the neighbours in window order, the centre left out
    localparam logic [7:0] LANE_CODE [LANES] = '{DIR_NW, DIR_N, DIR_NE, DIR_W,
                                                 DIR_E, DIR_SW, DIR_S, DIR_SE};
    localparam logic [LANES-1:0] LANE_DIAG = 8'b1010_0101;
    localparam int LANE_WIN [LANES] = '{0, 1, 2, 3, 5, 6, 7, 8};
    localparam int CENTRE_WIN = 4;

    typedef logic signed [ELEV_BITS-1:0]  elev_t;
    typedef logic signed [SCORE_BITS-1:0] score_t;

    typedef struct packed {
        elev_t         elev_nw;
        elev_t         elev_n;
        elev_t         elev_ne;
        elev_t         elev_w;
        elev_t         elev_center;
        elev_t         elev_e;
        elev_t         elev_sw;
        elev_t         elev_s;
        elev_t         elev_se;
        logic [8:0]    invalid_mask;
        logic [15:0]   pixel_row;
        logic [15:0]   pixel_col;
    } item_t;

    typedef struct packed {
        logic [7:0] direction_bits;
        logic       undefined;
    } result_t;

    typedef struct packed {
        logic                single_flow;
        logic                centre_invalid;
        logic [POS_BITS-1:0] pixel_row;
        logic [POS_BITS-1:0] pixel_col;
        logic [POS_BITS-1:0] last_row;
        logic [POS_BITS-1:0] last_col;
    } ctrl_t;

endpackage

FILE: design/tfd_lane.sv
module tfd_lane (
    input  logic                 clk,
    input  tfd_pkg::elev_t       centre,
    input  tfd_pkg::elev_t       neighbour,
    input  logic                 void_cell,
    input  logic                 diag,
    output tfd_pkg::score_t      score,
    output logic                 lower
);
    import tfd_pkg::*;

    logic signed [DROP_BITS-1:0]     drop;
    logic signed [DROP_BITS+16:0]    diag_prod;
    score_t                          score_next;
    score_t                          score_reg;
    logic                            lower_next;
    logic                            lower_reg;

    assign drop = {centre[ELEV_BITS-1], centre} - {neighbour[ELEV_BITS-1], neighbour};
    assign diag_prod = drop * $signed({1'b0, Q16_INV_SQRT2});

    always_comb
    begin
        if (diag)
        begin
            score_next = diag_prod[SCORE_BITS-1:0];
        end
        else
        begin
            score_next = {drop, 16'b0};
        end
        lower_next = (drop > 0) && !void_cell;
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        lower_reg <= lower_next;
    end

    assign score = score_reg;
    assign lower = lower_reg;

endmodule

FILE: design/tfd_merge.sv
module tfd_merge (
    input  tfd_pkg::score_t           score [tfd_pkg::LANES],
    input  logic [tfd_pkg::LANES-1:0] lower,
    input  tfd_pkg::ctrl_t            ctrl,
    output tfd_pkg::result_t          result
);
    import tfd_pkg::*;

    score_t                   lvl1_score [4];
    logic [LANE_IDX_BITS-1:0] lvl1_idx   [4];
    score_t                   lvl2_score [2];
    logic [LANE_IDX_BITS-1:0] lvl2_idx   [2];
    score_t                   best_score;
    logic [LANE_IDX_BITS-1:0] best_idx;
    logic [7:0]               mfd_bits;
    logic [7:0]               dir;
    logic                     top_row;
    logic                     bottom_row;
    logic                     hit;
    logic                     undef;

    // the left side keeps a tie, so the lowest window index wins
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (score[2*i] >= score[2*i+1])
            begin
                lvl1_score[i] = score[2*i];
                lvl1_idx[i]   = LANE_IDX_BITS'(2*i);
            end
            else
            begin
                lvl1_score[i] = score[2*i+1];
                lvl1_idx[i]   = LANE_IDX_BITS'(2*i+1);
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (lvl1_score[2*i] >= lvl1_score[2*i+1])
            begin
                lvl2_score[i] = lvl1_score[2*i];
                lvl2_idx[i]   = lvl1_idx[2*i];
            end
            else
            begin
                lvl2_score[i] = lvl1_score[2*i+1];
                lvl2_idx[i]   = lvl1_idx[2*i+1];
            end
        end
        if (lvl2_score[0] >= lvl2_score[1])
        begin
            best_score = lvl2_score[0];
            best_idx   = lvl2_idx[0];
        end
        else
        begin
            best_score = lvl2_score[1];
            best_idx   = lvl2_idx[1];
        end
    end

    always_comb
    begin
        mfd_bits = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (lower[i])
            begin
                mfd_bits = mfd_bits | LANE_CODE[i];
            end
        end
    end

    always_comb
    begin
        top_row    = (ctrl.pixel_row == '0);
        bottom_row = (ctrl.pixel_row == ctrl.last_row);
        hit        = 1'b0;
        undef      = ctrl.centre_invalid;
        dir        = '0;
        if (!ctrl.centre_invalid)
        begin
            if (ctrl.single_flow)
            begin
                dir = (best_score > 0) ? LANE_CODE[best_idx] : 8'd0;
            end
            else
            begin
                dir = mfd_bits;
            end
        end
        if ((dir == '0) || ctrl.centre_invalid)
        begin
            // later edges override earlier ones; corners go diagonally outward
            if (top_row)
            begin
                dir = ctrl.single_flow ? DIR_N : (DIR_NW | DIR_N | DIR_NE);
                hit = 1'b1;
            end
            if (bottom_row)
            begin
                dir = ctrl.single_flow ? DIR_S : (DIR_SE | DIR_S | DIR_SW);
                hit = 1'b1;
            end
            if (ctrl.pixel_col == '0)
            begin
                if (top_row)
                    dir = DIR_NW;
                else if (bottom_row)
                    dir = DIR_SW;
                else
                    dir = ctrl.single_flow ? DIR_W : (DIR_SW | DIR_W | DIR_NW);
                hit = 1'b1;
            end
            if (ctrl.pixel_col == ctrl.last_col)
            begin
                if (top_row)
                    dir = DIR_NE;
                else if (bottom_row)
                    dir = DIR_SE;
                else
                    dir = ctrl.single_flow ? DIR_E : (DIR_NE | DIR_E | DIR_SE);
                hit = 1'b1;
            end
            if (hit)
                undef = 1'b0;
            if (undef)
                dir = '0;
        end
        result.direction_bits = dir;
        result.undefined      = undef;
    end

endmodule

FILE: design/terrain_flow_direction_unit.sv
// Flow direction of one raster pixel per transaction. A new window may be started on every
// clock cycle and busy never rises; the result appears on result with result_strobe once the
// window has passed the eight neighbour lanes, which form the drop and its fixed-point
// score and register it, and then the merge, which picks the steepest lane or gathers the
// lower ones and applies the raster edge rules; its result is registered. The result is shown
// for a single cycle and cannot be held off, so it must be taken when the strobe is high.
// Configuration writes take effect at once and belong between transactions.
module terrain_flow_direction_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  tfd_pkg::item_t                        item,
    output logic                                  result_strobe,
    output tfd_pkg::result_t                      result,
    input  logic                                  cfg_we,
    input  logic [tfd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [tfd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import tfd_pkg::*;

    logic                  single_flow_reg;
    logic [POS_BITS-1:0]   row_count_reg;
    logic [POS_BITS-1:0]   column_count_reg;
    logic                  lane_valid_reg;
    logic                  out_valid_reg;
    ctrl_t                 ctrl_next;
    ctrl_t                 ctrl_reg;
    result_t               merge_result;
    result_t               result_reg;
    elev_t                 window [9];
    score_t                lane_score [LANES];
    logic [LANES-1:0]      lane_lower;
    logic                  accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign window = '{item.elev_nw, item.elev_n, item.elev_ne,
                      item.elev_w, item.elev_center, item.elev_e,
                      item.elev_sw, item.elev_s, item.elev_se};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_flow_reg  <= 1'b0;
            row_count_reg    <= 16'd1;
            column_count_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SINGLE_FLOW:  single_flow_reg  <= cfg_data[0];
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    generate
        for (genvar k = 0; k < LANES; k++)
        begin : g_lane
            tfd_lane u_lane (
                .clk       (clk),
                .centre    (window[CENTRE_WIN]),
                .neighbour (window[LANE_WIN[k]]),
                .void_cell (item.invalid_mask[LANE_WIN[k]]),
                .diag      (LANE_DIAG[k]),
                .score     (lane_score[k]),
                .lower     (lane_lower[k])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl_next.single_flow    = single_flow_reg;
        ctrl_next.centre_invalid = item.invalid_mask[CENTRE_WIN];
        ctrl_next.pixel_row      = item.pixel_row;
        ctrl_next.pixel_col      = item.pixel_col;
        ctrl_next.last_row       = row_count_reg - 16'd1;
        ctrl_next.last_col       = column_count_reg - 16'd1;
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg   <= ctrl_next;
        result_reg <= merge_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            lane_valid_reg <= accept;
            out_valid_reg  <= lane_valid_reg;
        end
    end

    tfd_merge u_merge (
        .score  (lane_score),
        .lower  (lane_lower),
        .ctrl   (ctrl_reg),
        .result (merge_result)
    );

    assign result_strobe = out_valid_reg;
    assign result        = result_reg;

    a_strobe_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(accept, 2))
        else $error("result strobe without a started transaction");

    a_undefined_clears_bits: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.undefined |-> result.direction_bits == '0)
        else $error("undefined result carries direction bits");

    a_undefined_needs_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        lane_valid_reg && merge_result.undefined |-> ctrl_reg.centre_invalid)
        else $error("undefined result with a valid centre");

    a_single_flow_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
        lane_valid_reg && ctrl_reg.single_flow && !ctrl_reg.centre_invalid
            |=> $onehot0(result.direction_bits))
        else $error("single flow result names more than one direction");

endmodule

FILE: verif/terrain_flow_direction_unit_tb.sv
`timescale 1ns / 1ps

module terrain_flow_direction_unit_tb;

    import tfd_pkg::*;

    localparam int PIPE_DEPTH = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam longint CARD_SCALE = 65536;
    localparam longint DIAG_SCALE = longint'(Q16_INV_SQRT2);
    localparam logic [8:0] NO_MASK = 9'h000;
    localparam logic [8:0] CENTRE_BAD = 9'h001 << CENTRE_WIN;
    localparam logic [7:0] NO_DIR = 8'h00;
    // direction code per window cell, centre has none
    localparam logic [7:0] CELL_DIR [9] = '{DIR_NW, DIR_N, DIR_NE, DIR_W, NO_DIR,
                                            DIR_E, DIR_SW, DIR_S, DIR_SE};

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    item_t                     window;
    logic                      result_strobe;
    result_t                   flow_result;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // register shadow
    logic        shadow_single_flow;
    logic [15:0] shadow_rows;
    logic [15:0] shadow_cols;

    result_t expected_flow [$];
    int      mismatch_count;

    terrain_flow_direction_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (window),
        .result_strobe (result_strobe),
        .result        (flow_result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic result_t predict_flow(item_t w);
        elev_t       win_elev [9];
        longint      drop;
        longint      score;
        longint      best;
        logic [7:0]  dir;
        logic        undef;
        logic        hit;
        logic [15:0] last_row;
        logic [15:0] last_col;
        result_t     r;
        win_elev = '{w.elev_nw, w.elev_n, w.elev_ne, w.elev_w, w.elev_center,
                     w.elev_e, w.elev_sw, w.elev_s, w.elev_se};
        last_row = shadow_rows - 16'd1;
        last_col = shadow_cols - 16'd1;
        dir = NO_DIR;
        undef = 1'b1;
        if (!w.invalid_mask[CENTRE_WIN])
        begin
            undef = 1'b0;
            best = 0;
            for (int i = 0; i < 9; i++)
            begin
                if (i == CENTRE_WIN)
                    continue;
                drop = longint'(win_elev[CENTRE_WIN]) - longint'(win_elev[i]);
                if (shadow_single_flow)
                begin
                    score = (i % 2 == 1) ? drop * CARD_SCALE : drop * DIAG_SCALE;
                    if (score > best)
                    begin
                        best = score;
                        dir = CELL_DIR[i];
                    end
                end
                else if (drop > 0 && !w.invalid_mask[i])
                    dir |= CELL_DIR[i];
            end
        end
        if (dir == NO_DIR || undef)
        begin
            hit = 1'b0;
            if (w.pixel_row == 16'd0)
            begin
                dir = shadow_single_flow ? DIR_N : (DIR_NW | DIR_N | DIR_NE);
                hit = 1'b1;
            end
            if (w.pixel_row == last_row)
            begin
                dir = shadow_single_flow ? DIR_S : (DIR_SE | DIR_S | DIR_SW);
                hit = 1'b1;
            end
            if (w.pixel_col == 16'd0)
            begin
                if (w.pixel_row == 16'd0)
                    dir = DIR_NW;
                else if (w.pixel_row == last_row)
                    dir = DIR_SW;
                else
                    dir = shadow_single_flow ? DIR_W : (DIR_SW | DIR_W | DIR_NW);
                hit = 1'b1;
            end
            if (w.pixel_col == last_col)
            begin
                if (w.pixel_row == 16'd0)
                    dir = DIR_NE;
                else if (w.pixel_row == last_row)
                    dir = DIR_SE;
                else
                    dir = shadow_single_flow ? DIR_E : (DIR_NE | DIR_E | DIR_SE);
                hit = 1'b1;
            end
            if (hit)
                undef = 1'b0;
            if (undef)
                dir = NO_DIR;
        end
        r.direction_bits = dir;
        r.undefined = undef;
        return r;
    endfunction

    function automatic item_t with_cell(item_t w, int idx, elev_t v);
        case (idx)
            0: w.elev_nw = v;
            1: w.elev_n = v;
            2: w.elev_ne = v;
            3: w.elev_w = v;
            4: w.elev_center = v;
            5: w.elev_e = v;
            6: w.elev_sw = v;
            7: w.elev_s = v;
            default: w.elev_se = v;
        endcase
        return w;
    endfunction

    function automatic item_t flat_window(elev_t centre, elev_t rest, logic [8:0] mask,
                                          logic [15:0] row, logic [15:0] col);
        item_t w;
        for (int i = 0; i < 9; i++)
            w = with_cell(w, i, rest);
        w.elev_center = centre;
        w.invalid_mask = mask;
        w.pixel_row = row;
        w.pixel_col = col;
        return w;
    endfunction

    function automatic logic [15:0] random_position(logic [15:0] count);
        logic [15:0] last;
        last = count - 16'd1;
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return last;
            2: return last - 16'd1;
            3: return 16'($urandom);
            4: return (count > 16'd2) ? 16'($urandom_range(1, count - 2)) : 16'd1;
            default: return 16'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic item_t random_window();
        item_t w;
        elev_t centre;
        int    style;
        int    delta;
        style = $urandom_range(0, 7);
        case ($urandom_range(0, 9))
            0: centre = 16'sh7fff;
            1: centre = 16'sh8000;
            default: centre = elev_t'($urandom);
        endcase
        for (int i = 0; i < 9; i++)
        begin
            delta = int'($urandom_range(0, 6)) - 3;
            if (style == 0)
                w = with_cell(w, i, elev_t'($urandom));
            else
                w = with_cell(w, i, elev_t'(int'(centre) + delta));
        end
        w.elev_center = centre;
        w.invalid_mask = ($urandom_range(0, 1) == 0) ? NO_MASK : 9'($urandom);
        w.pixel_row = random_position(shadow_rows);
        w.pixel_col = random_position(shadow_cols);
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_strobe)
        begin
            if (expected_flow.size() == 0)
                report_mismatch("unexpected result", flow_result.direction_bits, NO_DIR);
            else
            begin
                want = expected_flow.pop_front();
                if (flow_result.direction_bits !== want.direction_bits)
                    report_mismatch("direction_bits", flow_result.direction_bits,
                                    want.direction_bits);
                if (flow_result.undefined !== want.undefined)
                    report_mismatch("undefined", 8'(flow_result.undefined),
                                    8'(want.undefined));
            end
        end
    end

    // each cycle idles with the given chance, so that share of cycles is idle
    task automatic send_window(item_t w, int idle_pct);
        while (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        window <= w;
        do
            @(posedge clk);
        while (busy);
        expected_flow.push_back(predict_flow(w));
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        while (expected_flow.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SINGLE_FLOW: shadow_single_flow = val[0];
            REG_ROW_COUNT: shadow_rows = val;
            REG_COLUMN_COUNT: shadow_cols = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(logic single_flow, logic [15:0] rows, logic [15:0] cols);
        drain_pipeline();
        write_reg(REG_SINGLE_FLOW, {15'd0, single_flow});
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COLUMN_COUNT, cols);
    endtask

    // reset values: 1x1 raster, multiple flow; an unused index must change nothing
    task automatic test_reset_defaults();
        send_window(flat_window(16'sd5, 16'sd9, NO_MASK, 16'd0, 16'd0), 0);
        drain_pipeline();
        write_reg(REG_UNUSED, 16'hffff);
        send_window(with_cell(flat_window(16'sd5, 16'sd9, NO_MASK, 16'd0, 16'd0),
                              7, 16'sd1), 0);
    endtask

    task automatic test_multiple_flow();
        configure(1'b0, 16'd100, 16'd200);
        send_window(flat_window(16'sd0, -16'sd1, NO_MASK, 16'd50, 16'd50), 0);
        send_window(flat_window(16'sd0, -16'sd5, 9'b1_0100_1011, 16'd50, 16'd50), 0);
        send_window(flat_window(16'sh7fff, 16'sh8000, NO_MASK, 16'd50, 16'd50), 0);
        send_window(flat_window(16'sh8000, 16'sh7fff, NO_MASK, 16'd50, 16'd50), 0);
        send_window(flat_window(16'sd0, -16'sd1, CENTRE_BAD, 16'd50, 16'd50), 0);
        // flat ground on every edge and corner
        send_window(flat_window(16'sd3, 16'sd3, NO_MASK, 16'd0, 16'd50), 0);
        send_window(flat_window(16'sd3, 16'sd3, NO_MASK, 16'd99, 16'd50), 0);
        send_window(flat_window(16'sd3, 16'sd3, NO_MASK, 16'd50, 16'd0), 0);
        send_window(flat_window(16'sd3, 16'sd3, NO_MASK, 16'd50, 16'd199), 0);
        send_window(flat_window(16'sd3, 16'sd3, NO_MASK, 16'd0, 16'd0), 0);
        send_window(flat_window(16'sd3, 16'sd3, NO_MASK, 16'd0, 16'd199), 0);
        send_window(flat_window(16'sd3, 16'sd3, NO_MASK, 16'd99, 16'd0), 0);
        send_window(flat_window(16'sd3, 16'sd3, NO_MASK, 16'd99, 16'd199), 0);
        // a real drop on the edge is kept
        send_window(with_cell(flat_window(16'sd0, 16'sd0, NO_MASK, 16'd0, 16'd50),
                              7, -16'sd1), 0);
        send_window(flat_window(16'sd0, -16'sd1, CENTRE_BAD, 16'd50, 16'd199), 0);
    endtask

    task automatic test_single_flow();
        configure(1'b1, 16'd100, 16'd200);
        // diagonal drop of 3 beats cardinal drop of 2
        send_window(with_cell(with_cell(flat_window(16'sd10, 16'sd20, NO_MASK, 16'd50,
                    16'd50), 2, 16'sd7), 1, 16'sd8), 0);
        // equal drops: the cardinal scores higher
        send_window(with_cell(with_cell(flat_window(16'sd10, 16'sd20, NO_MASK, 16'd50,
                    16'd50), 0, 16'sd9), 3, 16'sd9), 0);
        // tie between cardinals goes to the lower window index
        send_window(with_cell(with_cell(flat_window(16'sd10, 16'sd20, NO_MASK, 16'd50,
                    16'd50), 7, 16'sd5), 1, 16'sd5), 0);
        send_window(with_cell(flat_window(16'sh7fff, 16'sh7fff, NO_MASK, 16'd50, 16'd50),
                              8, 16'sh8000), 0);
        send_window(flat_window(16'sd0, 16'sd1, NO_MASK, 16'd50, 16'd50), 0);
        // void neighbour still counts here
        send_window(with_cell(flat_window(16'sd0, 16'sd0, 9'h020, 16'd50, 16'd50),
                              5, -16'sd100), 0);
        send_window(flat_window(16'sd0, -16'sd1, CENTRE_BAD, 16'd0, 16'd50), 0);
    endtask

    // zero counts wrap the last index to all ones
    task automatic test_count_extremes();
        configure(1'b0, 16'd0, 16'd0);
        send_window(flat_window(16'sd1, 16'sd1, NO_MASK, 16'hffff, 16'hffff), 0);
        send_window(flat_window(16'sd1, 16'sd1, NO_MASK, 16'd0, 16'd0), 0);
        configure(1'b1, 16'hffff, 16'hffff);
        send_window(flat_window(16'sd1, 16'sd1, CENTRE_BAD, 16'hfffe, 16'hfffe), 0);
    endtask

    task automatic test_random_stream(int count, int idle_pct);
        for (int n = 0; n < count; n++)
            send_window(random_window(), idle_pct);
    endtask

    task automatic test_random_phases();
        int          idle_pct [3];
        logic [15:0] dims [2];
        idle_pct = '{8, 66, 0};
        for (int p = 0; p < 3; p++)
        begin
            for (int s = 0; s < 4; s++)
            begin
                for (int d = 0; d < 2; d++)
                begin
                    case ($urandom_range(0, 5))
                        0: dims[d] = 16'd1;
                        1: dims[d] = 16'hffff;
                        2: dims[d] = 16'd0;
                        default: dims[d] = 16'($urandom_range(2, 8));
                    endcase
                end
                configure(s[0], dims[0], dims[1]);
                test_random_stream(155, idle_pct[p]);
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        window <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_SINGLE_FLOW;
        cfg_data <= '0;
        shadow_single_flow = 1'b0;
        shadow_rows = 16'd1;
        shadow_cols = 16'd1;
        mismatch_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_multiple_flow();
        test_single_flow();
        test_count_extremes();
        test_random_phases();

        drain_pipeline();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
